// ===== hdl/verlet_particle_step_unit_defines.svh =====
// ---------------------------------------------------------------------------
// verlet particle step unit assertion macros
// shared property forms for the particle step block, clocked on aclk
// ---------------------------------------------------------------------------
`ifndef VERLET_PARTICLE_STEP_UNIT_DEFINES_SVH
`define VERLET_PARTICLE_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define VPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vps assertion failed");

// next-cycle implication
`define VPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vps assertion failed");

`endif

// ===== hdl/vps_pkg.sv =====
// ---------------------------------------------------------------------------
// vps_pkg
// types, codes and reset constants of the verlet particle step unit
// ---------------------------------------------------------------------------
package vps_pkg;

    localparam int POS_W      = 24;
    localparam int S_DATA_W   = 136;
    localparam int M_DATA_W   = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_FACTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ELASTICITY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_HEIGHT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PINNED        = 3'd7;

    localparam logic [3:0] STEP_NONE = 4'd0;
    localparam logic [3:0] STEP_SQ   = 4'd1;
    localparam logic [3:0] STEP_RR   = 4'd2;
    localparam logic [3:0] STEP_ACC  = 4'd3;
    localparam logic [3:0] STEP_DRAG = 4'd4;
    localparam logic [3:0] STEP_ADT  = 4'd5;
    localparam logic [3:0] STEP_VEL  = 4'd6;
    localparam logic [3:0] STEP_SUM  = 4'd7;
    localparam logic [3:0] STEP_POS  = 4'd8;

    localparam logic [19:0]        CURSOR_RADIUS_RST = 20'd5120;
    localparam logic [16:0]        DRAG_K_RST        = 17'd64881;
    localparam logic signed [30:0] ACC_X100_RST      = 31'sd0;
    localparam logic signed [30:0] ACC_Y100_RST      = 31'sd256000;
    localparam logic [19:0]        ELASTICITY_RST    = 20'd2560;
    localparam logic [14:0]        BOUND_W_RST       = 15'd800;
    localparam logic [14:0]        BOUND_H_RST       = 15'd600;

    localparam logic [POS_W-1:0] POS_MAX = 24'h7FFFFF;
    localparam logic [POS_W-1:0] POS_MIN = 24'h800000;

    typedef struct packed {
        logic       take;
        logic [3:0] step;
        logic       out_load;
    } vps_cmd_t;

    typedef struct packed {
        logic alive;
        logic pinned;
    } vps_stat_t;

    typedef struct packed {
        logic [19:0]        cursor_radius;
        logic [16:0]        drag_k;
        logic signed [30:0] acc_x100;
        logic signed [30:0] acc_y100;
        logic [19:0]        elasticity;
        logic [14:0]        bound_width;
        logic [14:0]        bound_height;
        logic               pinned;
    } vps_cfg_t;

    function automatic logic [POS_W-1:0] sat24(input logic signed [34:0] v);
        logic [POS_W-1:0] r;
        if ((v[34:23] == 12'h000) || (v[34:23] == 12'hFFF)) begin
            r = v[23:0];
        end else if (v[34]) begin
            r = POS_MIN;
        end else begin
            r = POS_MAX;
        end
        return r;
    endfunction

endpackage

// ===== hdl/vps_cfg.sv =====
// ---------------------------------------------------------------------------
// vps_cfg
// configuration registers, with drag and acceleration kept in working form
// ---------------------------------------------------------------------------
module vps_cfg import vps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output vps_cfg_t              cfg
);

    vps_cfg_t           cfg_reg;
    vps_cfg_t           cfg_next;
    logic signed [30:0] val31;
    logic signed [30:0] val100;

    assign cfg_ready = aresetn;
    assign cfg       = cfg_reg;

    // times 100 as 64 + 32 + 4
    assign val31  = {{7{cfg_data[23]}}, cfg_data};
    assign val100 = (val31 <<< 6) + (val31 <<< 5) + (val31 <<< 2);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CURSOR_RADIUS: cfg_next.cursor_radius = cfg_data[19:0];
                CFG_DRAG_FACTOR:   cfg_next.drag_k = 17'h10000 - {1'b0, cfg_data[15:0]};
                CFG_ACCEL_X:       cfg_next.acc_x100 = val100;
                CFG_ACCEL_Y:       cfg_next.acc_y100 = val100;
                CFG_ELASTICITY:    cfg_next.elasticity = cfg_data[19:0];
                CFG_BOUND_WIDTH:   cfg_next.bound_width = cfg_data[14:0];
                CFG_BOUND_HEIGHT:  cfg_next.bound_height = cfg_data[14:0];
                CFG_PINNED:        cfg_next.pinned = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cursor_radius <= CURSOR_RADIUS_RST;
            cfg_reg.drag_k        <= DRAG_K_RST;
            cfg_reg.acc_x100      <= ACC_X100_RST;
            cfg_reg.acc_y100      <= ACC_Y100_RST;
            cfg_reg.elasticity    <= ELASTICITY_RST;
            cfg_reg.bound_width   <= BOUND_W_RST;
            cfg_reg.bound_height  <= BOUND_H_RST;
            cfg_reg.pinned        <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/vps_ctrl.sv =====
// ---------------------------------------------------------------------------
// vps_ctrl
// sequencer for one particle request and the result handshake
// ---------------------------------------------------------------------------
module vps_ctrl import vps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic [1:0] op,
    input  vps_stat_t stat,
    output logic      m_tvalid,
    input  logic      m_tready,
    output vps_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_RR   = 4'd2;
    localparam logic [3:0] ST_ACC  = 4'd3;
    localparam logic [3:0] ST_DRAG = 4'd4;
    localparam logic [3:0] ST_ADT  = 4'd5;
    localparam logic [3:0] ST_VEL  = 4'd6;
    localparam logic [3:0] ST_SUM  = 4'd7;
    localparam logic [3:0] ST_POS  = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd.take     = s_tvalid && s_tready;
        cmd.step     = STEP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.take) begin
                    state_next = ((op == OP_UPDATE) && stat.alive) ? ST_SQ : ST_DONE;
                end
            end
            ST_SQ: begin
                cmd.step   = STEP_SQ;
                state_next = ST_RR;
            end
            ST_RR: begin
                cmd.step   = STEP_RR;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.step   = STEP_ACC;
                state_next = ST_DRAG;
            end
            ST_DRAG: begin
                cmd.step   = STEP_DRAG;
                state_next = stat.pinned ? ST_DONE : ST_ADT;
            end
            ST_ADT: begin
                cmd.step   = STEP_ADT;
                state_next = ST_VEL;
            end
            ST_VEL: begin
                cmd.step   = STEP_VEL;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.step   = STEP_SUM;
                state_next = ST_POS;
            end
            ST_POS: begin
                cmd.step   = STEP_POS;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait until the output register is free
                if (!(m_tvalid_reg && !m_tready)) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== hdl/vps_dp.sv =====
// ---------------------------------------------------------------------------
// vps_dp
// particle state, two multiplier lanes (x and y) and the result register
// ---------------------------------------------------------------------------
module vps_dp import vps_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  vps_cmd_t            cmd,
    output vps_stat_t           stat,
    input  vps_cfg_t            cfg,
    input  logic [1:0]          op,
    input  logic [POS_W-1:0]    pos_in_x,
    input  logic [POS_W-1:0]    pos_in_y,
    input  logic [15:0]         mouse_x,
    input  logic [15:0]         mouse_y,
    input  logic [15:0]         prev_mouse_x,
    input  logic [15:0]         prev_mouse_y,
    input  logic                left_button,
    input  logic                right_button,
    input  logic [15:0]         time_step,
    output logic [M_DATA_W-1:0] out_data
);

    // particle state
    logic [POS_W-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [POS_W-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [POS_W-1:0] home_x_reg, home_x_next, home_y_reg, home_y_next;
    logic             alive_reg, alive_next, hovered_reg, hovered_next;
    logic             destroy_reg, destroy_next;

    // latched request
    logic [15:0] mx_reg, mx_next, my_reg, my_next;
    logic [15:0] lmx_reg, lmx_next, lmy_reg, lmy_next;
    logic        left_reg, left_next, right_reg, right_next;
    logic [15:0] dt_reg, dt_next;

    // working registers
    logic signed [57:0] prod_x_reg, prod_y_reg;
    logic [50:0]        sq_sum_reg, sq_sum_next;
    logic [15:0]        dt2_reg, dt2_next;
    logic signed [31:0] acc_rx_reg, acc_rx_next, acc_ry_reg, acc_ry_next;
    logic signed [57:0] adt_x_reg, adt_x_next, adt_y_reg, adt_y_next;
    logic signed [33:0] dlt_x_reg, dlt_x_next, dlt_y_reg, dlt_y_next;
    logic [M_DATA_W-1:0] out_reg, out_next;

    // multiplier lanes
    logic signed [31:0] ma_x, ma_y;
    logic signed [25:0] mb_x, mb_y;
    logic signed [57:0] mul_x, mul_y;

    logic signed [24:0] dx, dy, vx, vy;
    logic signed [16:0] ddx, ddy;
    logic signed [24:0] shx, shy, lim, neg_lim, ex, ey;
    logic signed [57:0] rnd_x, rnd_y, tot_x, tot_y;
    logic [POS_W-1:0]   nx, ny, w24, h24;

    assign stat.alive  = alive_reg;
    assign stat.pinned = cfg.pinned;
    assign out_data    = out_reg;

    assign dx = {cur_x_reg[23], cur_x_reg} - {mx_reg[15], mx_reg, 8'h00};
    assign dy = {cur_y_reg[23], cur_y_reg} - {my_reg[15], my_reg, 8'h00};
    assign vx = {cur_x_reg[23], cur_x_reg} - {prev_x_reg[23], prev_x_reg};
    assign vy = {cur_y_reg[23], cur_y_reg} - {prev_y_reg[23], prev_y_reg};

    always_comb begin
        ma_x = '0;
        mb_x = '0;
        ma_y = '0;
        mb_y = '0;
        case (cmd.step)
            STEP_SQ: begin
                ma_x = {{7{dx[24]}}, dx};
                mb_x = {dx[24], dx};
                ma_y = {{7{dy[24]}}, dy};
                mb_y = {dy[24], dy};
            end
            STEP_RR: begin
                ma_x = {12'h000, cfg.cursor_radius};
                mb_x = {6'h00, cfg.cursor_radius};
                ma_y = {16'h0000, dt_reg};
                mb_y = {10'h000, dt_reg};
            end
            STEP_ACC: begin
                ma_x = {cfg.acc_x100[30], cfg.acc_x100};
                mb_x = {9'h000, cfg.drag_k};
                ma_y = {cfg.acc_y100[30], cfg.acc_y100};
                mb_y = {9'h000, cfg.drag_k};
            end
            STEP_ADT: begin
                ma_x = acc_rx_reg;
                mb_x = {10'h000, dt2_reg};
                ma_y = acc_ry_reg;
                mb_y = {10'h000, dt2_reg};
            end
            STEP_VEL: begin
                ma_x = {{7{vx[24]}}, vx};
                mb_x = {9'h000, cfg.drag_k};
                ma_y = {{7{vy[24]}}, vy};
                mb_y = {9'h000, cfg.drag_k};
            end
            default: begin
            end
        endcase
    end

    assign mul_x = ma_x * mb_x;
    assign mul_y = ma_y * mb_y;

    // drag displacement, clamped per axis
    assign ddx     = {mx_reg[15], mx_reg} - {lmx_reg[15], lmx_reg};
    assign ddy     = {my_reg[15], my_reg} - {lmy_reg[15], lmy_reg};
    assign shx     = {ddx, 8'h00};
    assign shy     = {ddy, 8'h00};
    assign lim     = {5'h00, cfg.elasticity};
    assign neg_lim = -lim;
    assign ex      = (shx > lim) ? lim : ((shx < neg_lim) ? neg_lim : shx);
    assign ey      = (shy > lim) ? lim : ((shy < neg_lim) ? neg_lim : shy);

    assign rnd_x = prod_x_reg + 58'sd32768;
    assign rnd_y = prod_y_reg + 58'sd32768;
    assign tot_x = prod_x_reg + adt_x_reg + 58'sd32768;
    assign tot_y = prod_y_reg + adt_y_reg + 58'sd32768;

    assign nx  = sat24($signed({{11{cur_x_reg[23]}}, cur_x_reg}) + $signed({dlt_x_reg[33], dlt_x_reg}));
    assign ny  = sat24($signed({{11{cur_y_reg[23]}}, cur_y_reg}) + $signed({dlt_y_reg[33], dlt_y_reg}));
    assign w24 = {1'b0, cfg.bound_width, 8'h00};
    assign h24 = {1'b0, cfg.bound_height, 8'h00};

    always_comb begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        home_x_next  = home_x_reg;
        home_y_next  = home_y_reg;
        alive_next   = alive_reg;
        hovered_next = hovered_reg;
        destroy_next = destroy_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        lmx_next     = lmx_reg;
        lmy_next     = lmy_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        dt_next      = dt_reg;
        sq_sum_next  = sq_sum_reg;
        dt2_next     = dt2_reg;
        acc_rx_next  = acc_rx_reg;
        acc_ry_next  = acc_ry_reg;
        adt_x_next   = adt_x_reg;
        adt_y_next   = adt_y_reg;
        dlt_x_next   = dlt_x_reg;
        dlt_y_next   = dlt_y_reg;

        if (cmd.take) begin
            mx_next      = mouse_x;
            my_next      = mouse_y;
            lmx_next     = prev_mouse_x;
            lmy_next     = prev_mouse_y;
            left_next    = left_button;
            right_next   = right_button;
            dt_next      = time_step;
            destroy_next = 1'b0;
            case (op)
                OP_INIT: begin
                    cur_x_next  = pos_in_x;
                    cur_y_next  = pos_in_y;
                    prev_x_next = pos_in_x;
                    prev_y_next = pos_in_y;
                    home_x_next = pos_in_x;
                    home_y_next = pos_in_y;
                    alive_next  = 1'b1;
                end
                OP_SET: begin
                    cur_x_next = pos_in_x;
                    cur_y_next = pos_in_y;
                end
                default: begin
                end
            endcase
        end

        case (cmd.step)
            STEP_RR: begin
                sq_sum_next = {1'b0, prod_x_reg[49:0]} + {1'b0, prod_y_reg[49:0]};
            end
            STEP_ACC: begin
                hovered_next = sq_sum_reg < {11'h000, prod_x_reg[39:0]};
                dt2_next     = rnd_y[31:16];
            end
            STEP_DRAG: begin
                acc_rx_next = rnd_x[47:16];
                acc_ry_next = rnd_y[47:16];
                if (left_reg && hovered_reg) begin
                    prev_x_next = sat24($signed({{11{cur_x_reg[23]}}, cur_x_reg})
                                        - $signed({{10{ex[24]}}, ex}));
                    prev_y_next = sat24($signed({{11{cur_y_reg[23]}}, cur_y_reg})
                                        - $signed({{10{ey[24]}}, ey}));
                end
                if (right_reg && hovered_reg) begin
                    alive_next   = 1'b0;
                    destroy_next = 1'b1;
                end
                if (cfg.pinned) begin
                    cur_x_next = home_x_reg;
                    cur_y_next = home_y_reg;
                end
            end
            STEP_VEL: begin
                adt_x_next = prod_x_reg;
                adt_y_next = prod_y_reg;
            end
            STEP_SUM: begin
                dlt_x_next = tot_x[49:16];
                dlt_y_next = tot_y[49:16];
            end
            STEP_POS: begin
                // left edge keeps the previous x
                prev_x_next = cur_x_reg;
                if ($signed(nx) > $signed(w24)) begin
                    cur_x_next  = w24;
                    prev_x_next = w24;
                end else if (nx[23]) begin
                    cur_x_next = '0;
                end else begin
                    cur_x_next = nx;
                end
                prev_y_next = cur_y_reg;
                if ($signed(ny) > $signed(h24)) begin
                    cur_y_next  = h24;
                    prev_y_next = h24;
                end else if (ny[23]) begin
                    cur_y_next  = '0;
                    prev_y_next = '0;
                end else begin
                    cur_y_next = ny;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_next = out_reg;
        if (cmd.out_load) begin
            out_next = {5'h00, destroy_reg, alive_reg, hovered_reg, cur_y_reg, cur_x_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            home_x_reg  <= '0;
            home_y_reg  <= '0;
            alive_reg   <= 1'b1;
            hovered_reg <= 1'b0;
            destroy_reg <= 1'b0;
        end else begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            home_x_reg  <= home_x_next;
            home_y_reg  <= home_y_next;
            alive_reg   <= alive_next;
            hovered_reg <= hovered_next;
            destroy_reg <= destroy_next;
        end
    end

    always_ff @(posedge aclk) begin
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        lmx_reg    <= lmx_next;
        lmy_reg    <= lmy_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        dt_reg     <= dt_next;
        prod_x_reg <= mul_x;
        prod_y_reg <= mul_y;
        sq_sum_reg <= sq_sum_next;
        dt2_reg    <= dt2_next;
        acc_rx_reg <= acc_rx_next;
        acc_ry_reg <= acc_ry_next;
        adt_x_reg  <= adt_x_next;
        adt_y_reg  <= adt_y_next;
        dlt_x_reg  <= dlt_x_next;
        dlt_y_reg  <= dlt_y_next;
        out_reg    <= out_next;
    end

endmodule

// ===== hdl/verlet_particle_step_unit.sv =====
// init, set, ignored requests and updates of an inactive particle go straight to
// the result; an update runs the eight steps over the two multiplier lanes, and a
// pinned one stops after the drag step; a new request is taken only once the last
// result is loaded, and a held result stalls that load
// reset: synchronous active-low aresetn clears positions, sets active, restores
// register defaults; both ready outputs stay low while aresetn is low
// ---------------------------------------------------------------------------
// verlet_particle_step_unit
// one cloth particle: placement, mouse selection and drag, damped verlet step
// ---------------------------------------------------------------------------
`include "verlet_particle_step_unit_defines.svh"

module verlet_particle_step_unit import vps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_in_x, pos_in_y, mouse_x, mouse_y, prev_mouse_x, prev_mouse_y,
    // left_button, right_button, time_step, zero fill
    input  logic [S_DATA_W-1:0]   s_tdata,
    // op
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pos_out_x, pos_out_y, is_selected, is_active, destroy_links, zero fill
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    vps_cfg_t  cfg;
    vps_cmd_t  cmd;
    vps_stat_t stat;

    vps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    vps_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg          (cfg),
        .op           (s_tuser),
        .pos_in_x     (s_tdata[23:0]),
        .pos_in_y     (s_tdata[47:24]),
        .mouse_x      (s_tdata[63:48]),
        .mouse_y      (s_tdata[79:64]),
        .prev_mouse_x (s_tdata[95:80]),
        .prev_mouse_y (s_tdata[111:96]),
        .left_button  (s_tdata[112]),
        .right_button (s_tdata[113]),
        .time_step    (s_tdata[129:114]),
        .out_data     (m_tdata)
    );

    `VPS_ASSERT_SAME(a_no_overwrite, cmd.out_load, !(m_tvalid && !m_tready))
    `VPS_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)
    `VPS_ASSERT_SAME(a_destroy_inactive, m_tvalid && m_tdata[50], !m_tdata[49])

endmodule

// ===== test/tb_verlet_particle_step_unit.sv =====
// ---------------------------------------------------------------------------
// tb_verlet_particle_step_unit
// Self-checking bench for the cloth particle step unit. A directed table
// covers placement, the extreme positions, the window clamps, drag, removal
// and the inactive particle. Randomized phases follow, each under its own
// register setting, with extreme settings among them. Each result is checked
// against a typed row's expectation, else a cycle-free particle model.
// ---------------------------------------------------------------------------
module tb_verlet_particle_step_unit import vps_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         RAND_PHASES = 7;
    localparam int         PHASE_REQS  = 58;
    localparam int         DRAIN_CYCLES = 12;
    localparam longint     CYCLE_LIMIT = 300000;

    typedef struct {
        logic [1:0]         op;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] lmx;
        logic signed [15:0] lmy;
        logic               lb;
        logic               rb;
        logic [15:0]        dt;
    } particle_req_t;

    typedef struct {
        logic [23:0] x;
        logic [23:0] y;
        logic        sel;
        logic        act;
        logic        dest;
    } particle_rsp_t;

    typedef struct {
        particle_req_t req;
        bit            typed;
        particle_rsp_t rsp;
    } table_row_t;

    typedef struct {
        logic [19:0] radius;
        logic [15:0] drag;
        logic [23:0] ax;
        logic [23:0] ay;
        logic [19:0] elast;
        logic [14:0] bw;
        logic [14:0] bh;
        logic        pin;
    } particle_cfg_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [1:0]            s_tuser = OP_INIT;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CURSOR_RADIUS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register copy
    logic [19:0]        c_radius = 20'd5120;
    logic [15:0]        c_drag   = 16'd655;
    logic signed [23:0] c_ax     = 24'sd0;
    logic signed [23:0] c_ay     = 24'sd2560;
    logic [19:0]        c_elast  = 20'd2560;
    logic [14:0]        c_bw     = 15'd800;
    logic [14:0]        c_bh     = 15'd600;
    logic               c_pin    = 1'b0;

    // particle state
    longint st_cur_x = 0, st_cur_y = 0, st_prev_x = 0, st_prev_y = 0;
    longint st_home_x = 0, st_home_y = 0;
    bit     st_alive = 1'b1, st_hovered = 1'b0;

    particle_rsp_t pending_rsp_q[$];
    table_row_t    directed_rows[$];

    int     idle_pct = 17;
    int     n_errors = 0;
    int     n_reqs = 0, n_results = 0, n_settings = 0;
    int     n_selected = 0, n_dragged = 0, n_removed = 0, n_pinned = 0;
    longint cycle_cnt = 0;

    verlet_particle_step_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end

    function automatic longint sat_pos(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint to_s16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint verlet_axis(input longint c, input longint p, input longint acc,
                                           input longint k, input longint dt2);
        longint a;
        longint sum;
        a   = (acc * 100 * k + 32768) >>> 16;
        sum = (c - p) * k + a * dt2 + 32768;
        return sat_pos(c + (sum >>> 16));
    endfunction

    function automatic particle_rsp_t particle_step(input particle_req_t r);
        longint        dx, dy, rr, k, dt2, nx, ny, w, h;
        logic          destroy;
        particle_rsp_t o;
        destroy = 1'b0;
        if (r.op == OP_INIT) begin
            st_cur_x = r.px; st_prev_x = r.px; st_home_x = r.px;
            st_cur_y = r.py; st_prev_y = r.py; st_home_y = r.py;
            st_alive = 1'b1;
        end else if (r.op == OP_SET) begin
            st_cur_x = r.px;
            st_cur_y = r.py;
        end else if (r.op == OP_UPDATE && st_alive) begin
            dx = st_cur_x - longint'(r.mx) * 256;
            dy = st_cur_y - longint'(r.my) * 256;
            rr = longint'(c_radius) * longint'(c_radius);
            st_hovered = (dx * dx + dy * dy) < rr;
            if (st_hovered) n_selected++;
            if (r.lb && st_hovered) begin
                st_prev_x = sat_pos(st_cur_x - clamp_sym((longint'(r.mx) - longint'(r.lmx)) * 256,
                                                         longint'(c_elast)));
                st_prev_y = sat_pos(st_cur_y - clamp_sym((longint'(r.my) - longint'(r.lmy)) * 256,
                                                         longint'(c_elast)));
                n_dragged++;
            end
            if (r.rb && st_hovered) begin
                st_alive = 1'b0;
                destroy  = 1'b1;
                n_removed++;
            end
            if (c_pin) begin
                st_cur_x = st_home_x;
                st_cur_y = st_home_y;
                n_pinned++;
            end else begin
                k   = 65536 - longint'(c_drag);
                dt2 = (longint'(r.dt) * longint'(r.dt) + 32768) >>> 16;
                nx  = verlet_axis(st_cur_x, st_prev_x, longint'(c_ax), k, dt2);
                ny  = verlet_axis(st_cur_y, st_prev_y, longint'(c_ay), k, dt2);
                w   = longint'(c_bw) * 256;
                h   = longint'(c_bh) * 256;
                st_prev_x = st_cur_x;
                st_prev_y = st_cur_y;
                st_cur_x  = nx;
                st_cur_y  = ny;
                // left edge keeps the old x history
                if (st_cur_x > w) begin
                    st_cur_x  = w;
                    st_prev_x = w;
                end else if (st_cur_x < 0) begin
                    st_cur_x = 0;
                end
                if (st_cur_y > h) begin
                    st_cur_y  = h;
                    st_prev_y = h;
                end else if (st_cur_y < 0) begin
                    st_cur_y  = 0;
                    st_prev_y = 0;
                end
            end
        end
        o.x    = st_cur_x[23:0];
        o.y    = st_cur_y[23:0];
        o.sel  = st_hovered;
        o.act  = st_alive;
        o.dest = destroy;
        return o;
    endfunction

    function automatic particle_req_t mk_req(input logic [1:0] op, input longint px,
                                             input longint py, input longint mx,
                                             input longint my, input longint lmx,
                                             input longint lmy, input int lb,
                                             input int rb, input longint dt);
        particle_req_t r;
        r.op  = op;
        r.px  = 24'(px);
        r.py  = 24'(py);
        r.mx  = 16'(mx);
        r.my  = 16'(my);
        r.lmx = 16'(lmx);
        r.lmy = 16'(lmy);
        r.lb  = 1'(lb);
        r.rb  = 1'(rb);
        r.dt  = 16'(dt);
        return r;
    endfunction

    function automatic particle_rsp_t mk_rsp(input logic [23:0] x, input logic [23:0] y,
                                             input logic sel, input logic act,
                                             input logic dest);
        particle_rsp_t o;
        o.x = x; o.y = y; o.sel = sel; o.act = act; o.dest = dest;
        return o;
    endfunction

    task automatic add_row(input particle_req_t r, input int typed, input particle_rsp_t o);
        table_row_t row;
        row.req   = r;
        row.typed = (typed != 0);
        row.rsp   = o;
        directed_rows.push_back(row);
    endtask

    function automatic particle_req_t rand_req();
        particle_req_t r;
        int            pick, span, off;
        pick  = $urandom_range(99);
        r.op  = OP_UPDATE;
        r.px  = 24'($urandom());
        r.py  = 24'($urandom());
        r.mx  = 16'($urandom());
        r.my  = 16'($urandom());
        r.lmx = 16'($urandom());
        r.lmy = 16'($urandom());
        r.lb  = 1'($urandom_range(1));
        r.rb  = 1'($urandom_range(1));
        r.dt  = 16'($urandom());
        if (pick < 5) begin
            r.op = OP_UNUSED;
        end else if (pick < 12) begin
            r.op = OP_UPDATE;
        end else if (pick < 22 || (!st_alive && pick < 60)) begin
            r.op = (!st_alive || pick % 2 == 0) ? OP_INIT : OP_SET;
            if ($urandom_range(3) != 0) begin
                r.px = 24'($urandom_range(0, int'(c_bw) * 256));
                r.py = 24'($urandom_range(0, int'(c_bh) * 256));
            end
        end else begin
            // mouse near the particle so selection, drag and removal get exercised
            span = int'(c_radius >> 8) + 4;
            if (span > 300) span = 300;
            off  = int'($urandom_range(0, 2 * span)) - span;
            r.mx = 16'(to_s16((st_cur_x >>> 8) + off));
            off  = int'($urandom_range(0, 2 * span)) - span;
            r.my = 16'(to_s16((st_cur_y >>> 8) + off));
            off   = int'($urandom_range(0, 50)) - 25;
            r.lmx = 16'(to_s16(longint'(r.mx) + off));
            off   = int'($urandom_range(0, 50)) - 25;
            r.lmy = 16'(to_s16(longint'(r.my) + off));
            r.lb  = ($urandom_range(99) < 50);
            r.rb  = ($urandom_range(99) < 6);
            if ($urandom_range(99) < 70) r.dt = 16'($urandom_range(256, 2048));
        end
        return r;
    endfunction

    function automatic particle_cfg_t rand_cfg();
        particle_cfg_t c;
        c.radius = ($urandom_range(99) < 75) ? 20'($urandom_range(256 * 5, 256 * 60))
                                             : 20'($urandom());
        c.drag   = ($urandom_range(99) < 60) ? 16'($urandom_range(0, 3000))
                                             : 16'($urandom());
        c.ax     = ($urandom_range(99) < 60) ? 24'(int'($urandom_range(0, 10240)) - 5120)
                                             : 24'($urandom());
        c.ay     = ($urandom_range(99) < 60) ? 24'(int'($urandom_range(0, 10240)) - 5120)
                                             : 24'($urandom());
        c.elast  = ($urandom_range(99) < 70) ? 20'($urandom_range(0, 256 * 40))
                                             : 20'($urandom());
        c.bw     = ($urandom_range(99) < 70) ? 15'($urandom_range(100, 2000))
                                             : 15'($urandom());
        c.bh     = ($urandom_range(99) < 70) ? 15'($urandom_range(100, 2000))
                                             : 15'($urandom());
        c.pin    = ($urandom_range(99) < 25);
        return c;
    endfunction

    task automatic send_req(input particle_req_t r, input bit typed, input particle_rsp_t o);
        particle_rsp_t p;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {6'b0, r.dt, r.rb, r.lb, r.lmy, r.lmx, r.my, r.mx, r.py, r.px};
        do @(posedge aclk); while (!s_tready);
        p = particle_step(r);
        pending_rsp_q.push_back(typed ? o : p);
        n_reqs++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CURSOR_RADIUS: c_radius = val[19:0];
            CFG_DRAG_FACTOR:   c_drag   = val[15:0];
            CFG_ACCEL_X:       c_ax     = val;
            CFG_ACCEL_Y:       c_ay     = val;
            CFG_ELASTICITY:    c_elast  = val[19:0];
            CFG_BOUND_WIDTH:   c_bw     = val[14:0];
            CFG_BOUND_HEIGHT:  c_bh     = val[14:0];
            CFG_PINNED:        c_pin    = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input particle_cfg_t c);
        write_reg(CFG_CURSOR_RADIUS, {4'b0, c.radius});
        write_reg(CFG_DRAG_FACTOR,   {8'b0, c.drag});
        write_reg(CFG_ACCEL_X,       c.ax);
        write_reg(CFG_ACCEL_Y,       c.ay);
        write_reg(CFG_ELASTICITY,    {4'b0, c.elast});
        write_reg(CFG_BOUND_WIDTH,   {9'b0, c.bw});
        write_reg(CFG_BOUND_HEIGHT,  {9'b0, c.bh});
        write_reg(CFG_PINNED,        {23'b0, c.pin});
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic drain();
        while (pending_rsp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input longint e, input longint a);
        if (e != a) begin
            $error("%s mismatch: expected %0h, actual %0h", name, e, a);
            n_errors++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        particle_rsp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_rsp_q.size() == 0) begin
                $error("result with no pending request");
                n_errors++;
            end else begin
                e = pending_rsp_q.pop_front();
                check_field("pos_out_x",     e.x,    m_tdata[23:0]);
                check_field("pos_out_y",     e.y,    m_tdata[47:24]);
                check_field("is_selected",   e.sel,  m_tdata[48]);
                check_field("is_active",     e.act,  m_tdata[49]);
                check_field("destroy_links", e.dest, m_tdata[50]);
            end
        end
    end

    initial begin
        particle_cfg_t cfg;
        particle_rsp_t none;
        none = mk_rsp('0, '0, 1'b0, 1'b0, 1'b0);

        // ignored code after reset, extreme placements, window clamps
        add_row(mk_req(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(24'h0, 24'h0, 1'b0, 1'b1, 1'b0));
        add_row(mk_req(OP_INIT, 8388607, 8388607, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b1, 1'b0));
        add_row(mk_req(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0444), 0, none);
        add_row(mk_req(OP_INIT, -8388608, -8388608, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(24'h800000, 24'h800000, 1'b0, 1'b1, 1'b0));
        add_row(mk_req(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, none);
        add_row(mk_req(OP_INIT, 25600, 25600, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(24'd25600, 24'd25600, 1'b0, 1'b1, 1'b0));
        add_row(mk_req(OP_SET, 30720, 28160, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(24'd30720, 24'd28160, 1'b0, 1'b1, 1'b0));
        // drag beyond the elasticity limit, then a small one
        add_row(mk_req(OP_UPDATE, 0, 0, 120, 110, 90, 140, 1, 0, 16'hFFFF), 0, none);
        add_row(mk_req(OP_UPDATE, 0, 0, 121, 111, 120, 110, 1, 0, 16'h0444), 0, none);
        // right click on the particle, then the inactive particle
        add_row(mk_req(OP_SET, 30720, 28160, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk_req(OP_UPDATE, 0, 0, 120, 110, 120, 110, 0, 1, 16'h0444), 0, none);
        add_row(mk_req(OP_UPDATE, 0, 0, 120, 110, 100, 100, 1, 1, 16'h0444), 0, none);
        add_row(mk_req(OP_SET, 1000, 2000, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk_req(OP_UNUSED, -1, -1, -1, -1, -1, -1, 1, 1, 16'hFFFF), 0, none);
        add_row(mk_req(OP_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        // mouse field extremes
        add_row(mk_req(OP_UPDATE, 0, 0, -32768, -32768, 32767, 32767, 1, 1, 16'h0000), 0,
                none);
        add_row(mk_req(OP_UPDATE, 0, 0, 32767, 32767, -32768, -32768, 1, 1, 16'hFFFF), 0,
                none);
        add_row(mk_req(OP_SET, 8388607, -8388608, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk_req(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0444), 0, none);
        add_row(mk_req(OP_SET, 51200, 51200, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk_req(OP_UPDATE, 0, 0, 200, 200, 198, 203, 1, 0, 16'h0444), 0, none);
        add_row(mk_req(OP_UPDATE, 0, 0, 201, 199, 200, 200, 0, 0, 16'h0800), 0, none);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
        end
        s_tvalid <= 1'b0;

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            if (p == 0) begin
                // widest radius, no drag, no elasticity, zero-size window
                cfg.radius = 20'hFFFFF; cfg.drag = 16'h0;    cfg.ax = 24'h7FFFFF;
                cfg.ay     = 24'h800000; cfg.elast = 20'h0;  cfg.bw = 15'h0;
                cfg.bh     = 15'h0;     cfg.pin = 1'b0;
            end else if (p == 1) begin
                // no radius, full drag, largest window, pinned
                cfg.radius = 20'h0;      cfg.drag = 16'hFFFF;    cfg.ax = 24'h800000;
                cfg.ay     = 24'h7FFFFF; cfg.elast = 20'hFFFFF;  cfg.bw = 15'h7FFF;
                cfg.bh     = 15'h7FFF;   cfg.pin = 1'b1;
            end else begin
                cfg = rand_cfg();
            end
            idle_pct = (p == 4) ? 0 : 17;
            configure(cfg);
            repeat (PHASE_REQS) send_req(rand_req(), 1'b0, none);
            s_tvalid <= 1'b0;
        end

        drain();
        repeat (20) @(posedge aclk);

        $display("covered %0d requests under %0d register settings, %0d results checked",
                 n_reqs, n_settings + 1, n_results);
        $display("ticks: %0d selected, %0d dragged, %0d removed, %0d pinned",
                 n_selected, n_dragged, n_removed, n_pinned);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
